// ===== rtl/metronome_click_generator_macros.svh =====
// assertion macros for the metronome click generator
// used by metronome_click_generator.sv, expects clk and arst_n in scope
`ifndef METRONOME_CLICK_GENERATOR_MACROS_SVH
`define METRONOME_CLICK_GENERATOR_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define MCG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define MCG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mcg_pkg.sv =====
// types, constants and helpers for the metronome click generator
// no dependencies
package mcg_pkg;

	localparam int SAMPLE_RATE_DEF = 48000;

	// bits of pos << 8 walked by the serial divider
	localparam int POS_W   = 41;
	localparam int DVD_W   = POS_W + 8;

	localparam logic [14:0] AMP_ACCENT = 15'd26214;
	localparam logic [14:0] AMP_NORMAL = 15'd16384;

	localparam logic signed [17:0] SIN_C0 = 18'sd51472;
	localparam logic signed [17:0] SIN_C1 = 18'sd21167;
	localparam logic signed [17:0] SIN_C2 = 18'sd2611;
	localparam logic signed [17:0] SIN_C3 = 18'sd153;

	// register indexes
	localparam logic [2:0] REG_ENABLE      = 3'd0;
	localparam logic [2:0] REG_LEVEL       = 3'd1;
	localparam logic [2:0] REG_SPC         = 3'd2;
	localparam logic [2:0] REG_BPB         = 3'd3;
	localparam logic [2:0] REG_LOOP_ENABLE = 3'd4;
	localparam logic [2:0] REG_LOOP_START  = 3'd5;
	localparam logic [2:0] REG_LOOP_END    = 3'd6;

	localparam logic [15:0] LEVEL_RST = 16'd32768;
	localparam logic [31:0] SPC_RST   = 32'd5644800;
	localparam logic [6:0]  BPB_RST   = 7'd4;

	typedef struct packed {
		logic [39:0]        block_start;
		logic [11:0]        sample_offset;
		logic               playing;
		logic signed [15:0] mix_in;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] mix_out;
		logic               click_fired;
		logic               click_accented;
	} out_item_t;

	// divide by 32768 truncating toward zero
	function automatic logic signed [17:0] trunc15(input logic signed [35:0] p);
		logic signed [35:0] q;
		q = p >>> 15;
		if (p[35] && (p[14:0] != 15'd0)) begin
			q = q + 36'sd1;
		end
		return q[17:0];
	endfunction

endpackage

// ===== rtl/metronome_click_generator.sv =====
// metronome click generator: takes no new item until the last one is posted, paced by the
// bit-serial 49-step restoring divider of pos*256 by samples_per_click
// pass-through items go from POS1 straight to FIN and skip the divider
// the click sine and envelope run on one shared multiplier alongside the divider
// arst_n clears control state and click state, config registers take their defaults
// depends on mcg_pkg and metronome_click_generator_macros.svh
`include "metronome_click_generator_macros.svh"

module metronome_click_generator #(
	parameter int SAMPLE_RATE = mcg_pkg::SAMPLE_RATE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [5:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  mcg_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output mcg_pkg::out_item_t  out_item
);

	localparam int CLICK_LEN_RAW = (SAMPLE_RATE + 50) / 100;
	localparam int CLICK_LEN = (CLICK_LEN_RAW > 0) ? CLICK_LEN_RAW : 1;
	localparam int LW  = $clog2(CLICK_LEN + 1);
	localparam int ENW = 15 + LW;
	localparam int ECW = $clog2(ENW);
	localparam longint unsigned INC_A_L =
		((64'd1000 << 32) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
	localparam longint unsigned INC_N_L =
		((64'd800 << 32) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
	localparam logic [31:0] INC_ACCENT = INC_A_L[31:0];
	localparam logic [31:0] INC_NORMAL = INC_N_L[31:0];
	localparam logic [5:0] DIV_LAST = 6'(mcg_pkg::DVD_W - 1);
	localparam logic [ECW-1:0] ENV_LAST = ECW'(ENW - 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_POS1 = 6'b000010,
		ST_POS2 = 6'b000100,
		ST_POS3 = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	typedef enum logic [11:0] {
		CS_SQ    = 12'b000000000001,
		CS_T0    = 12'b000000000010,
		CS_T1    = 12'b000000000100,
		CS_T2    = 12'b000000001000,
		CS_T3    = 12'b000000010000,
		CS_S     = 12'b000000100000,
		CS_ENVLD = 12'b000001000000,
		CS_ENV   = 12'b000010000000,
		CS_SENV  = 12'b000100000000,
		CS_V     = 12'b001000000000,
		CS_LVL   = 12'b010000000000,
		CS_DONE  = 12'b100000000000
	} cstep_t;

	// configuration
	logic        enable_q;
	logic [15:0] level_q;
	logic [31:0] spc_q;
	logic [6:0]  bpb_q;
	logic        loop_en_q;
	logic [39:0] loop_start_q;
	logic [39:0] loop_end_q;

	// click state
	logic        click_active_q;
	logic [11:0] click_count_q;
	logic [31:0] osc_phase_q;
	logic        accent_q;

	state_t             state_q;
	cstep_t             cs_q;
	mcg_pkg::in_item_t  in_q;
	logic               pass_q;
	logic               lpok_q;
	logic [40:0]        pos_q;
	logic [41:0]        diff_q;
	logic [48:0]        dvd_q;
	logic [31:0]        rem_q;
	logic [6:0]         mod_q;
	logic [5:0]         dcnt_q;

	logic signed [35:0] prod_q;
	logic signed [17:0] x2_q;
	logic signed [17:0] s_q;
	logic signed [17:0] v_q;
	logic signed [17:0] scaled_q;
	logic               lvl_q;
	logic [ENW-1:0]     en_q;
	logic [LW-1:0]      er_q;
	logic [ECW-1:0]     ecnt_q;

	logic               out_valid_q;
	mcg_pkg::out_item_t out_item_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			level_q      <= mcg_pkg::LEVEL_RST;
			spc_q        <= mcg_pkg::SPC_RST;
			bpb_q        <= mcg_pkg::BPB_RST;
			loop_en_q    <= 1'b0;
			loop_start_q <= 40'd0;
			loop_end_q   <= 40'd0;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				mcg_pkg::REG_ENABLE:      enable_q     <= pwdata[0];
				mcg_pkg::REG_LEVEL:       level_q      <= pwdata[15:0];
				mcg_pkg::REG_SPC:         spc_q        <= pwdata[31:0];
				mcg_pkg::REG_BPB:         bpb_q        <= pwdata[6:0];
				mcg_pkg::REG_LOOP_ENABLE: loop_en_q    <= pwdata[0];
				mcg_pkg::REG_LOOP_START:  loop_start_q <= pwdata[39:0];
				mcg_pkg::REG_LOOP_END:    loop_end_q   <= pwdata[39:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			mcg_pkg::REG_ENABLE:      prdata = {63'd0, enable_q};
			mcg_pkg::REG_LEVEL:       prdata = {48'd0, level_q};
			mcg_pkg::REG_SPC:         prdata = {32'd0, spc_q};
			mcg_pkg::REG_BPB:         prdata = {57'd0, bpb_q};
			mcg_pkg::REG_LOOP_ENABLE: prdata = {63'd0, loop_en_q};
			mcg_pkg::REG_LOOP_START:  prdata = {24'd0, loop_start_q};
			mcg_pkg::REG_LOOP_END:    prdata = {24'd0, loop_end_q};
			default:                  prdata = 64'd0;
		endcase
	end

	// handshake
	logic accept;
	logic fin_go;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign fin_go    = (state_q == ST_FIN) && (pass_q || (cs_q == CS_DONE))
		&& (!out_valid_q || !out_stall);

	// serial divide step and beat modulo
	logic [32:0] div_t;
	logic        div_ge;
	logic [7:0]  mod_t;
	logic [40:0] pos_new;
	assign div_t   = {rem_q, dvd_q[48]};
	assign div_ge  = div_t >= {1'b0, spc_q};
	assign mod_t   = {mod_q, div_ge};
	assign pos_new = (lpok_q && !diff_q[41]) ? ({1'b0, loop_start_q} + diff_q[40:0]) : pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dcnt_q  <= 6'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_POS1;
					end
				end
				ST_POS1: state_q <= pass_q ? ST_FIN : ST_POS2;
				ST_POS2: state_q <= ST_POS3;
				ST_POS3: begin
					dcnt_q  <= 6'd0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == DIV_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q   <= in_item;
			pass_q <= !enable_q || (level_q == 16'd0) || !in_item.playing
				|| (spc_q == 32'd0) || (bpb_q == 7'd0);
		end
		if (state_q == ST_POS1) begin
			pos_q  <= {1'b0, in_q.block_start} + {29'd0, in_q.sample_offset};
			lpok_q <= loop_en_q && (loop_end_q > loop_start_q)
				&& (in_q.block_start < loop_end_q);
		end
		if (state_q == ST_POS2) begin
			diff_q <= {1'b0, pos_q} - {2'b0, loop_end_q};
		end
		if (state_q == ST_POS3) begin
			dvd_q <= {pos_new, 8'd0};
			rem_q <= 32'd0;
			mod_q <= 7'd0;
		end
		if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[47:0], 1'b0};
			rem_q <= div_ge ? 32'(div_t - {1'b0, spc_q}) : div_t[31:0];
			mod_q <= (mod_t >= {1'b0, bpb_q}) ? 7'(mod_t - {1'b0, bpb_q}) : mod_t[6:0];
		end
	end

	// click sample on a shared multiplier, for a slot that does not fire
	logic [1:0]         quad;
	logic [15:0]        xs;
	logic signed [17:0] prod_hi;
	logic signed [17:0] mul_a;
	logic signed [17:0] mul_b;
	logic [14:0]        amp;
	logic [LW:0]        env_t;
	logic               env_ge;

	assign quad    = osc_phase_q[31:30];
	assign xs      = quad[0] ? (16'd32768 - {1'b0, osc_phase_q[29:15]})
		: {1'b0, osc_phase_q[29:15]};
	assign prod_hi = prod_q[32:15];
	assign amp     = accent_q ? mcg_pkg::AMP_ACCENT : mcg_pkg::AMP_NORMAL;
	assign env_t   = {er_q, en_q[ENW-1]};
	assign env_ge  = env_t >= (LW+1)'(CLICK_LEN);

	always_comb begin
		case (cs_q)
			CS_SQ: begin
				mul_a = {2'b0, xs};
				mul_b = {2'b0, xs};
			end
			CS_T0: begin
				mul_a = mcg_pkg::SIN_C3;
				mul_b = prod_hi;
			end
			CS_T1: begin
				mul_a = mcg_pkg::SIN_C2 - prod_hi;
				mul_b = x2_q;
			end
			CS_T2: begin
				mul_a = mcg_pkg::SIN_C1 - prod_hi;
				mul_b = x2_q;
			end
			CS_T3: begin
				mul_a = mcg_pkg::SIN_C0 - prod_hi;
				mul_b = {2'b0, xs};
			end
			CS_S: begin
				mul_a = {3'b0, amp};
				mul_b = 18'(CLICK_LEN) - {6'd0, click_count_q};
			end
			CS_SENV: begin
				mul_a = s_q;
				mul_b = {3'b0, en_q[14:0]};
			end
			CS_LVL: begin
				mul_a = v_q;
				mul_b = {2'b0, level_q};
			end
			default: begin
				mul_a = 18'sd0;
				mul_b = 18'sd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= CS_DONE;
		end else begin
			case (cs_q)
				CS_SQ:    cs_q <= CS_T0;
				CS_T0:    cs_q <= CS_T1;
				CS_T1:    cs_q <= CS_T2;
				CS_T2:    cs_q <= CS_T3;
				CS_T3:    cs_q <= CS_S;
				CS_S:     cs_q <= CS_ENVLD;
				CS_ENVLD: cs_q <= CS_ENV;
				CS_ENV: begin
					if (ecnt_q == ENV_LAST) begin
						cs_q <= CS_SENV;
					end
				end
				CS_SENV:  cs_q <= CS_V;
				CS_V:     cs_q <= CS_LVL;
				CS_LVL:   cs_q <= CS_DONE;
				CS_DONE: begin
					if (state_q == ST_POS1 && !pass_q && click_active_q) begin
						cs_q <= CS_SQ;
					end
				end
				default:  cs_q <= CS_DONE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 36'(mul_a * mul_b);
		lvl_q  <= (cs_q == CS_LVL);
		if (state_q == ST_POS1) begin
			scaled_q <= 18'sd0;
		end
		case (cs_q)
			CS_T0: x2_q <= prod_hi;
			CS_S:  s_q  <= quad[1] ? -prod_hi : prod_hi;
			CS_ENVLD: begin
				en_q   <= prod_q[ENW-1:0];
				er_q   <= '0;
				ecnt_q <= '0;
			end
			CS_ENV: begin
				en_q   <= {en_q[ENW-2:0], env_ge};
				er_q   <= env_ge ? LW'(env_t - (LW+1)'(CLICK_LEN)) : env_t[LW-1:0];
				ecnt_q <= ecnt_q + 1'b1;
			end
			CS_V:  v_q <= mcg_pkg::trunc15(prod_q);
			CS_LVL: ;
			default: ;
		endcase
		if (cs_q == CS_LVL) begin
			// the product of v and level is registered in prod_q and taken in CS_DONE
			scaled_q <= 18'sd0;
		end
		if (cs_q == CS_DONE && state_q != ST_POS1 && lvl_q) begin
			scaled_q <= mcg_pkg::trunc15(prod_q);
		end
	end

	// finish: flags, mix sum and click state update
	logic               fired;
	logic               acc;
	logic signed [18:0] sum;
	logic signed [15:0] mix_sat;
	logic               b_active;
	logic               b_acc;
	logic [11:0]        b_count;
	logic [31:0]        b_phase;
	logic [11:0]        cnt1;

	assign fired = (rem_q[31:8] == 24'd0);
	assign acc   = fired && (mod_q == 7'd0);
	assign sum   = {{3{in_q.mix_in[15]}}, in_q.mix_in}
		+ (fired ? 19'sd0 : {scaled_q[17], scaled_q});

	always_comb begin
		if (sum > 19'sd32767) begin
			mix_sat = 16'sh7fff;
		end else if (sum < -19'sd32768) begin
			mix_sat = 16'sh8000;
		end else begin
			mix_sat = sum[15:0];
		end
		b_active = fired ? 1'b1 : click_active_q;
		b_acc    = fired ? acc : accent_q;
		b_count  = fired ? 12'd0 : click_count_q;
		b_phase  = fired ? 32'd0 : osc_phase_q;
		cnt1     = b_count + 12'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_active_q <= 1'b0;
			click_count_q  <= 12'd0;
			osc_phase_q    <= 32'd0;
			accent_q       <= 1'b0;
		end else if (fin_go && !pass_q) begin
			accent_q <= b_acc;
			if (b_active) begin
				osc_phase_q <= b_phase + (b_acc ? INC_ACCENT : INC_NORMAL);
				if ({20'd0, cnt1} >= 32'(CLICK_LEN)) begin
					click_active_q <= 1'b0;
					click_count_q  <= 12'd0;
				end else begin
					click_active_q <= 1'b1;
					click_count_q  <= cnt1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_stall == 1'b0) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			if (pass_q) begin
				out_item_q.mix_out        <= in_q.mix_in;
				out_item_q.click_fired    <= 1'b0;
				out_item_q.click_accented <= 1'b0;
			end else begin
				out_item_q.mix_out        <= mix_sat;
				out_item_q.click_fired    <= fired;
				out_item_q.click_accented <= acc;
			end
		end
	end

	`MCG_ASSERT_NOW(a_idle_count, !click_active_q, click_count_q == 12'd0, "idle click with count")
	`MCG_ASSERT_NOW(a_count_range, 1'b1, {20'd0, click_count_q} < 32'(CLICK_LEN), "click count past length")
	`MCG_ASSERT_NOW(a_accent_fired, out_valid_q && out_item_q.click_accented, out_item_q.click_fired, "accent without click")
	`MCG_ASSERT_NEXT(a_fin_result, fin_go, out_valid_q && (state_q == ST_IDLE), "result not posted")

endmodule
